// File: rtl/isawp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval seat allocator package
// Sizes, codes and request bundles shared by the allocator modules.
// ----------------------------------------------------------------------------
package isawp_pkg;

  localparam int MAX_SEATS    = 64;
  localparam int MAX_STATIONS = 20;
  localparam int ACCEL_STEP   = 2;

  localparam int SEAT_W     = $clog2(MAX_SEATS);
  localparam int SEAT_CNT_W = $clog2(MAX_SEATS + 1);
  localparam int STN_W      = 5;
  localparam int SPEED_W    = 10;
  localparam int DIST_W     = 16;
  localparam int PERSON_W   = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int DIST_DEPTH  = MAX_STATIONS - 1;
  localparam int DIST_ADDR_W = $clog2(DIST_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_BOOK  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SEATS    = 2'd0,
    CFG_NUM_STATIONS = 2'd1,
    CFG_MAX_SPEED    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // Request bundle for the occupancy map.
  typedef struct packed {
    logic                    rd_en;
    logic [SEAT_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [SEAT_W-1:0]       wr_addr;
    logic [MAX_STATIONS-1:0] wr_data;
  } occ_req_t;

  // Request bundle for the distance table.
  typedef struct packed {
    logic                   rd_en;
    logic [DIST_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [DIST_ADDR_W-1:0] wr_addr;
    logic [DIST_W-1:0]      wr_data;
  } dist_req_t;

endpackage

// File: rtl/isawp_occ_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy map memory
// One word of segment bits per seat, registered read, per-entry valid bits
// so that the whole map reads as free right after reset.
// ----------------------------------------------------------------------------
module isawp_occ_mem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isawp_pkg::occ_req_t                 req_i,
  output logic [isawp_pkg::MAX_STATIONS-1:0]  rd_data_o
);

  logic [isawp_pkg::MAX_STATIONS-1:0] mem [isawp_pkg::MAX_SEATS];
  logic [isawp_pkg::MAX_SEATS-1:0]    vld_q;
  logic [isawp_pkg::MAX_STATIONS-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      // An entry never written since reset is free on every segment.
      rd_data_q <= vld_q[req_i.rd_addr] ? mem[req_i.rd_addr] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/isawp_dist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance table memory
// One distance per route segment, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module isawp_dist_mem (
  input  logic                          clk_i,
  input  isawp_pkg::dist_req_t          req_i,
  output logic [isawp_pkg::DIST_W-1:0]  rd_data_o
);

  logic [isawp_pkg::DIST_W-1:0] mem [isawp_pkg::DIST_DEPTH];
  logic [isawp_pkg::DIST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/interval_seat_allocator_with_progress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval seat allocator with vehicle progress
// Books first-fit seats over station intervals and tracks the vehicle's
// station, speed and distance to the next station.
// ----------------------------------------------------------------------------
// A booking that is refused up front goes straight to the result step; any
// other booking scans the map memory, which is read one seat per cycle.
// Throughput: one item at a time; the next input beat is taken once the
// result sits in the output register. Reset is asynchronous, clears the map
// and the position and restores the configuration defaults; the distance
// table is not cleared.
// ----------------------------------------------------------------------------
module interval_seat_allocator_with_progress (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [isawp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [isawp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [isawp_pkg::KIND_W-1:0]       kind_i,
  input  logic [isawp_pkg::PERSON_W-1:0]     person_i,
  input  logic [isawp_pkg::STN_W-1:0]        from_station_i,
  input  logic [isawp_pkg::STN_W-1:0]        to_station_i,
  input  logic [isawp_pkg::DIST_W-1:0]       distance_value_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               seat_ok_o,
  output logic [isawp_pkg::SEAT_W-1:0]       seat_o,
  output logic                               passed_o,
  output logic [isawp_pkg::STN_W-1:0]        station_o,
  output logic [isawp_pkg::SPEED_W-1:0]      speed_o,
  output logic [isawp_pkg::DIST_W-1:0]       remaining_o
);

  // The sequencer walks through these steps for every beat. Booking spends
  // most of its time in the scan, which issues one map read per cycle and
  // checks the data returned in the next cycle.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_MOVE,
    S_LOAD,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [isawp_pkg::SEAT_CNT_W-1:0] num_seats_q;
  logic [isawp_pkg::STN_W-1:0]      num_stations_q;
  logic [isawp_pkg::SPEED_W-1:0]    max_speed_q;

  // Vehicle position.
  logic [isawp_pkg::STN_W-1:0]   station_q;
  logic [isawp_pkg::SPEED_W-1:0] speed_q;
  logic [isawp_pkg::DIST_W-1:0]  dist_q;

  // Captured input beat.
  isawp_pkg::kind_e               kind_q;
  logic [isawp_pkg::PERSON_W-1:0] person_q;
  logic [isawp_pkg::STN_W-1:0]    from_q;
  logic [isawp_pkg::STN_W-1:0]    to_q;
  logic [isawp_pkg::DIST_W-1:0]   dval_q;

  // Scan state: segment mask, next read index, and the read in flight.
  logic [isawp_pkg::MAX_STATIONS-1:0] mask_q;
  logic [isawp_pkg::SEAT_CNT_W-1:0]   rd_idx_q;
  logic                               pend_q;
  logic [isawp_pkg::SEAT_W-1:0]       pend_idx_q;

  // Result of the current beat.
  logic                         ok_q;
  logic [isawp_pkg::SEAT_W-1:0] seat_q;
  logic                         passed_q;

  // Output register.
  logic                          out_valid_q;
  logic                          out_ok_q;
  logic [isawp_pkg::SEAT_W-1:0]  out_seat_q;
  logic                          out_passed_q;
  logic [isawp_pkg::STN_W-1:0]   out_station_q;
  logic [isawp_pkg::SPEED_W-1:0] out_speed_q;
  logic [isawp_pkg::DIST_W-1:0]  out_dist_q;

  // Memories.
  isawp_pkg::occ_req_t                occ_req;
  logic [isawp_pkg::MAX_STATIONS-1:0] occ_rdata;
  isawp_pkg::dist_req_t               dist_req;
  logic [isawp_pkg::DIST_W-1:0]       dist_rdata;

  // Derived values.
  logic [isawp_pkg::SEAT_CNT_W-1:0]   seats_eff;
  logic [isawp_pkg::STN_W-1:0]        stations_eff;
  logic [isawp_pkg::STN_W-1:0]        last_stn;
  logic                               in_accept;
  logic                               out_take;
  logic                               out_free;
  logic                               book_refused;
  logic [isawp_pkg::MAX_STATIONS-1:0] mask_d;
  logic                               scan_more;
  logic                               scan_hit;
  logic [isawp_pkg::SPEED_W:0]        spd_sum;
  logic [isawp_pkg::SPEED_W-1:0]      spd_acc;
  logic [isawp_pkg::DIST_W-1:0]       dist_move;
  logic [isawp_pkg::STN_W-1:0]        stn_next;
  logic                               stn_has_dist;
  logic                               passed_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Counts above the built-in sizes act as those sizes.
  assign seats_eff = (num_seats_q > isawp_pkg::SEAT_CNT_W'(isawp_pkg::MAX_SEATS))
                   ? isawp_pkg::SEAT_CNT_W'(isawp_pkg::MAX_SEATS) : num_seats_q;
  assign stations_eff = (num_stations_q > isawp_pkg::STN_W'(isawp_pkg::MAX_STATIONS))
                      ? isawp_pkg::STN_W'(isawp_pkg::MAX_STATIONS) : num_stations_q;
  assign last_stn = (stations_eff != '0) ? stations_eff - 1'b1 : '0;

  // A booking is refused outright when the interval is empty, runs past the
  // route, or starts at a station the vehicle has already left behind.
  assign book_refused = (from_q >= to_q) || (to_q > stations_eff) || (station_q > from_q);

  // Segment mask covers the source up to, but not including, the destination.
  always_comb begin
    for (int b = 0; b < isawp_pkg::MAX_STATIONS; b++) begin
      mask_d[b] = (isawp_pkg::STN_W'(b) >= from_q) && (isawp_pkg::STN_W'(b) < to_q);
    end
  end

  // Scan: issue a read while seats remain, test the word that came back.
  assign scan_more = (rd_idx_q < seats_eff);
  assign scan_hit  = pend_q && ((occ_rdata & mask_q) == '0);

  always_comb begin
    occ_req         = '0;
    occ_req.rd_en   = (state_q == S_SCAN) && scan_more && !scan_hit;
    occ_req.rd_addr = rd_idx_q[isawp_pkg::SEAT_W-1:0];
    // A person id of zero is granted a seat but marks nothing.
    occ_req.wr_en   = (state_q == S_SCAN) && scan_hit && (person_q != '0);
    occ_req.wr_addr = pend_idx_q;
    occ_req.wr_data = occ_rdata | mask_q;
  end

  // Tick arithmetic, one add and compare per step.
  assign spd_sum = {1'b0, speed_q} + (isawp_pkg::SPEED_W + 1)'(isawp_pkg::ACCEL_STEP);
  assign spd_acc = (spd_sum <= {1'b0, max_speed_q})
                 ? spd_sum[isawp_pkg::SPEED_W-1:0] : max_speed_q;
  assign dist_move = (dist_q < isawp_pkg::DIST_W'(speed_q))
                   ? '0 : dist_q - isawp_pkg::DIST_W'(speed_q);
  assign stn_next  = station_q + 1'b1;
  assign stn_has_dist = (stn_next < last_stn)
                     && (stn_next < isawp_pkg::STN_W'(isawp_pkg::DIST_DEPTH));

  // Query: the station is behind the vehicle, or the vehicle is leaving it.
  assign passed_d = (station_q > from_q) || ((station_q == from_q) && (speed_q != '0));

  always_comb begin
    dist_req         = '0;
    dist_req.rd_en   = (state_q == S_MOVE) && (dist_move == '0) && stn_has_dist;
    dist_req.rd_addr = stn_next[isawp_pkg::DIST_ADDR_W-1:0];
    dist_req.wr_en   = (state_q == S_START) && (kind_q == isawp_pkg::KIND_LOAD)
                    && (from_q < isawp_pkg::STN_W'(isawp_pkg::DIST_DEPTH));
    dist_req.wr_addr = from_q[isawp_pkg::DIST_ADDR_W-1:0];
    dist_req.wr_data = dval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      num_seats_q    <= isawp_pkg::SEAT_CNT_W'(isawp_pkg::MAX_SEATS);
      num_stations_q <= isawp_pkg::STN_W'(isawp_pkg::MAX_STATIONS);
      max_speed_q    <= '0;
      station_q      <= '0;
      speed_q        <= '0;
      dist_q         <= '0;
      kind_q         <= isawp_pkg::KIND_BOOK;
      person_q       <= '0;
      from_q         <= '0;
      to_q           <= '0;
      dval_q         <= '0;
      mask_q         <= '0;
      rd_idx_q       <= '0;
      pend_q         <= 1'b0;
      pend_idx_q     <= '0;
      ok_q           <= 1'b0;
      seat_q         <= '0;
      passed_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_ok_q       <= 1'b0;
      out_seat_q     <= '0;
      out_passed_q   <= 1'b0;
      out_station_q  <= '0;
      out_speed_q    <= '0;
      out_dist_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (isawp_pkg::cfg_idx_e'(cfg_index_i))
          isawp_pkg::CFG_NUM_SEATS:    num_seats_q    <= cfg_data_i[isawp_pkg::SEAT_CNT_W-1:0];
          isawp_pkg::CFG_NUM_STATIONS: num_stations_q <= cfg_data_i[isawp_pkg::STN_W-1:0];
          isawp_pkg::CFG_MAX_SPEED:    max_speed_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // In the done step the output register is reloaded instead.
      if (out_take && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q   <= isawp_pkg::kind_e'(kind_i);
            person_q <= person_i;
            from_q   <= from_station_i;
            to_q     <= to_station_i;
            dval_q   <= distance_value_i;
            state_q  <= S_START;
          end
        end

        S_START: begin
          ok_q     <= 1'b0;
          seat_q   <= '0;
          passed_q <= (kind_q == isawp_pkg::KIND_QUERY) && passed_d;
          case (kind_q)
            isawp_pkg::KIND_BOOK: begin
              mask_q   <= mask_d;
              rd_idx_q <= '0;
              pend_q   <= 1'b0;
              state_q  <= book_refused ? S_DONE : S_SCAN;
            end
            isawp_pkg::KIND_TICK: begin
              // At the last station the trip is over and nothing moves.
              if (station_q >= last_stn) begin
                state_q <= S_DONE;
              end else begin
                if (speed_q < max_speed_q) begin
                  speed_q <= spd_acc;
                end
                state_q <= S_MOVE;
              end
            end
            isawp_pkg::KIND_QUERY: begin
              state_q <= S_DONE;
            end
            default: begin
              // Loading the first segment also sets the distance while the
              // vehicle still stands at the first station.
              if ((from_q == '0) && (station_q == '0) && (speed_q == '0)) begin
                dist_q <= dval_q;
              end
              state_q <= S_DONE;
            end
          endcase
        end

        S_SCAN: begin
          if (scan_hit) begin
            ok_q    <= 1'b1;
            seat_q  <= pend_idx_q;
            state_q <= S_DONE;
          end else if (scan_more) begin
            pend_q     <= 1'b1;
            pend_idx_q <= rd_idx_q[isawp_pkg::SEAT_W-1:0];
            rd_idx_q   <= rd_idx_q + 1'b1;
          end else if (!pend_q) begin
            state_q <= S_DONE;
          end else begin
            pend_q <= 1'b0;
          end
        end

        S_MOVE: begin
          if (dist_move == '0) begin
            station_q <= stn_next;
            speed_q   <= '0;
            dist_q    <= '0;
            state_q   <= stn_has_dist ? S_LOAD : S_DONE;
          end else begin
            dist_q  <= dist_move;
            state_q <= S_DONE;
          end
        end

        S_LOAD: begin
          dist_q  <= dist_rdata;
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_ok_q      <= ok_q;
            out_seat_q    <= seat_q;
            out_passed_q  <= passed_q;
            out_station_q <= station_q;
            out_speed_q   <= speed_q;
            out_dist_q    <= dist_q;
            state_q       <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  isawp_occ_mem u_occ_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (occ_req),
    .rd_data_o (occ_rdata)
  );

  isawp_dist_mem u_dist_mem (
    .clk_i     (clk_i),
    .req_i     (dist_req),
    .rd_data_o (dist_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign seat_ok_o   = out_ok_q;
  assign seat_o      = out_seat_q;
  assign passed_o    = out_passed_q;
  assign station_o   = out_station_q;
  assign speed_o     = out_speed_q;
  assign remaining_o = out_dist_q;

  // The map is only ever written by a successful scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_req.wr_en |-> (state_q == S_SCAN) && pend_q)
    else $error("occupancy map written outside a successful scan");

  // Once an input beat is taken, the block stalls until the item is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken while an item is still in progress");

  // A granted seat always lies among the seats in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && ok_q |-> ({1'b0, seat_q} < seats_eff))
    else $error("granted seat beyond the seats in use");

endmodule
